// File: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/cbdq_pkg.sv
package cbdq_pkg;

   // Store geometry.
   localparam int DEPTH      = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Widths of the request and response fields.
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 6;

   // Operation carried by each request.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   // Outcome reported with each response.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic execute;   // carry out the request presented on the input side
   } cmd_type;

endpackage

// File: src/cbdq_datapath.sv
`include "assert_macros.svh"

module cbdq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  cbdq_pkg::cmd_type                 cmd,
   input  cbdq_pkg::op_type                  operation,
   input  logic [cbdq_pkg::VALUE_W-1:0]      push_value,
   output logic [cbdq_pkg::VALUE_W-1:0]      popped_value,
   output cbdq_pkg::status_type              status,
   output logic [cbdq_pkg::OCC_W-1:0]        occupancy
);

   localparam logic [cbdq_pkg::IDX_W-1:0] LAST_SLOT  = cbdq_pkg::IDX_W'(cbdq_pkg::DEPTH - 1);
   localparam logic [cbdq_pkg::CNT_W-1:0] FULL_COUNT = cbdq_pkg::CNT_W'(cbdq_pkg::DEPTH);

   // Circular store.
   logic [cbdq_pkg::DATA_WIDTH-1:0] mem [cbdq_pkg::DEPTH];

   logic [cbdq_pkg::IDX_W-1:0]      head_ff, head_in;
   logic [cbdq_pkg::IDX_W-1:0]      tail_ff, tail_in;
   logic [cbdq_pkg::CNT_W-1:0]      count_ff, count_in;
   cbdq_pkg::status_type            status_ff, status_in;
   logic                            pop_ok_ff, pop_ok_in;
   logic [cbdq_pkg::DATA_WIDTH-1:0] rd_data_ff;

   logic                            wr_en;
   logic [cbdq_pkg::IDX_W-1:0]      wr_addr;
   logic [cbdq_pkg::IDX_W-1:0]      rd_addr;
   logic [cbdq_pkg::DATA_WIDTH-1:0] wr_word;
   logic                            is_push;
   logic                            is_front;
   logic                            empty;
   logic                            full;

   function automatic logic [cbdq_pkg::IDX_W-1:0] slot_next(
      input logic [cbdq_pkg::IDX_W-1:0] s
   );
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [cbdq_pkg::IDX_W-1:0] slot_prev(
      input logic [cbdq_pkg::IDX_W-1:0] s
   );
      return (s == '0) ? LAST_SLOT : s - 1'b1;
   endfunction

   // Decode the request and the occupancy.
   assign is_push  = (operation == cbdq_pkg::OP_PUSH_FRONT) ||
                     (operation == cbdq_pkg::OP_PUSH_BACK);
   assign is_front = (operation == cbdq_pkg::OP_PUSH_FRONT) ||
                     (operation == cbdq_pkg::OP_POP_FRONT);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_COUNT);
   assign wr_word  = cbdq_pkg::DATA_WIDTH'(push_value);

   // Pointer, count and store-access updates for one request.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = cbdq_pkg::ST_DONE;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      rd_addr   = head_ff;
      if (cmd.execute) begin
         if (is_push) begin
            if (full) begin
               status_in = cbdq_pkg::ST_FULL;
            end else begin
               // An empty store restarts both ends at slot zero.
               if (empty) begin
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (is_front) begin
                  head_in = slot_prev(head_ff);
                  wr_addr = slot_prev(head_ff);
               end else begin
                  tail_in = slot_next(tail_ff);
                  wr_addr = slot_next(tail_ff);
               end
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = cbdq_pkg::ST_EMPTY;
            end else begin
               rd_addr   = is_front ? head_ff : tail_ff;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
               // Removing the last entry sends both ends back to slot zero.
               if (count_ff == cbdq_pkg::CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (is_front) begin
                  head_in = slot_next(head_ff);
               end else begin
                  tail_in = slot_prev(tail_ff);
               end
            end
         end
      end
   end

   // Pointer and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Result registers, loaded once per request.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   // Store write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      if (cmd.execute) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Response fields.
   assign popped_value = pop_ok_ff ? cbdq_pkg::VALUE_W'(rd_data_ff) : '0;
   assign status       = status_ff;
   assign occupancy    = cbdq_pkg::OCC_W'(count_ff);

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "count above depth")
   `ASSERT_SAME(a_empty_ptrs, clock, reset, empty, (head_ff == '0) && (tail_ff == '0), "empty store with stray pointers")
   `ASSERT_SAME(a_single_ptrs, clock, reset, count_ff == cbdq_pkg::CNT_W'(1), head_ff == tail_ff, "single entry with ends apart")
   `ASSERT_NEXT(a_full_hold, clock, reset, cmd.execute && is_push && full, (status_ff == cbdq_pkg::ST_FULL) && $stable(count_ff), "refused push changed the count")

endmodule

// File: src/cbdq_ctrl.sv
`include "assert_macros.svh"

module cbdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output cbdq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RESP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Take a request when idle, then hold the response until it is taken.
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.execute = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid && !req_tready, "request without response")
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")
   `ASSERT_SAME(a_one_side, clock, reset, 1'b1, !(req_tready && rsp_tvalid), "request taken while response pending")

endmodule

// File: src/circular_buffer_deque_core.sv
// Channel   Direction  tdata                                 tuser
// req_      in         [31:0] push_value                     [1:0] operation
// rsp_      out        [31:0] popped_value, [37:32] occupancy [1:0] status
//
// The store and pointers update on the cycle the request is taken, and the
// response is offered from the next cycle on. The registered store read and
// the controller, which takes no request while a response is pending, mean
// that a new request is taken only after the last response has gone.
// Reset is synchronous and active high; it empties the queue.
// A stalled response holds the block: no new request is taken until it goes.
module circular_buffer_deque_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] popped_value, [37:32] occupancy, zero fill
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   cbdq_pkg::cmd_type                 cmd;
   cbdq_pkg::status_type              status;
   logic [cbdq_pkg::VALUE_W-1:0]      popped_value;
   logic [cbdq_pkg::OCC_W-1:0]        occupancy;

   cbdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cbdq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .operation    (cbdq_pkg::op_type'(req_tuser)),
      .push_value   (req_tdata),
      .popped_value (popped_value),
      .status       (status),
      .occupancy    (occupancy)
   );

   // Pack the response.
   assign rsp_tdata = {2'b00, occupancy, popped_value};
   assign rsp_tuser = status;

endmodule

// File: test/circular_buffer_deque_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque core. Every request taken is run through a
// local copy of the deque, and every response taken is compared with the oldest
// prediction still waiting.
module circular_buffer_deque_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] popped_value, [37:32] occupancy, zero fill
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          mismatch_count,
   output int          outstanding
);

   // One predicted response.
   typedef struct packed {
      logic [cbdq_pkg::VALUE_W-1:0] popped;
      cbdq_pkg::status_type         status;
      logic [cbdq_pkg::OCC_W-1:0]   occupancy;
   } deque_result_type;

   // Local copy of the deque.
   logic [cbdq_pkg::DATA_WIDTH-1:0] deque_words [cbdq_pkg::DEPTH];
   logic [cbdq_pkg::IDX_W-1:0]      front_slot;
   logic [cbdq_pkg::IDX_W-1:0]      back_slot;
   int unsigned                     held_count;

   deque_result_type pending_results [$];
   int               fail_tally = 0;

   // Prints one line per failure and counts it.
   task automatic report_failure(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_tally++;
   endtask

   function automatic logic [cbdq_pkg::IDX_W-1:0] slot_after(
      input logic [cbdq_pkg::IDX_W-1:0] s
   );
      return (s == cbdq_pkg::IDX_W'(cbdq_pkg::DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [cbdq_pkg::IDX_W-1:0] slot_before(
      input logic [cbdq_pkg::IDX_W-1:0] s
   );
      return (s == '0) ? cbdq_pkg::IDX_W'(cbdq_pkg::DEPTH - 1) : s - 1'b1;
   endfunction

   // Applies one request to the local deque and works out its response.
   task automatic step_deque(input cbdq_pkg::op_type op,
                             input logic [cbdq_pkg::VALUE_W-1:0] value,
                             output deque_result_type res);
      logic [cbdq_pkg::IDX_W-1:0] slot;
      res.popped = '0;
      res.status = cbdq_pkg::ST_DONE;
      case (op)
         cbdq_pkg::OP_PUSH_FRONT, cbdq_pkg::OP_PUSH_BACK: begin
            if (held_count >= cbdq_pkg::DEPTH) begin
               res.status = cbdq_pkg::ST_FULL;
            end else begin
               // A push into an empty deque always lands in slot zero.
               if (held_count == 0) begin
                  front_slot = '0;
                  back_slot  = '0;
               end else if (op == cbdq_pkg::OP_PUSH_FRONT) begin
                  front_slot = slot_before(front_slot);
               end else begin
                  back_slot = slot_after(back_slot);
               end
               slot = (op == cbdq_pkg::OP_PUSH_FRONT) ? front_slot : back_slot;
               deque_words[slot] = value[cbdq_pkg::DATA_WIDTH-1:0];
               held_count++;
            end
         end
         default: begin
            if (held_count == 0) begin
               res.status = cbdq_pkg::ST_EMPTY;
            end else begin
               slot = (op == cbdq_pkg::OP_POP_FRONT) ? front_slot : back_slot;
               res.popped = cbdq_pkg::VALUE_W'(deque_words[slot]);
               held_count--;
               // Taking the last entry brings both ends back to slot zero.
               if (held_count == 0) begin
                  front_slot = '0;
                  back_slot  = '0;
               end else if (op == cbdq_pkg::OP_POP_FRONT) begin
                  front_slot = slot_after(front_slot);
               end else begin
                  back_slot = slot_before(back_slot);
               end
            end
         end
      endcase
      res.occupancy = cbdq_pkg::OCC_W'(held_count);
   endtask

   // Responses are handled before requests so that a response taken in the same
   // cycle as a new request is matched against older predictions only.
   always @(posedge clock) begin
      deque_result_type want;
      deque_result_type got;
      if (reset) begin
         pending_results.delete();
         front_slot = '0;
         back_slot  = '0;
         held_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.popped    = rsp_tdata[31:0];
            got.occupancy = rsp_tdata[37:32];
            got.status    = cbdq_pkg::status_type'(rsp_tuser);
            if (pending_results.size() == 0) begin
               report_failure($sformatf("response with nothing expected: tdata 0x%0h tuser %0d",
                                        rsp_tdata, rsp_tuser));
            end else begin
               want = pending_results.pop_front();
               if (got.popped !== want.popped)
                  report_failure($sformatf("popped_value got 0x%08h, expected 0x%08h",
                                           got.popped, want.popped));
               if (got.status !== want.status)
                  report_failure($sformatf("status got %0d, expected %s",
                                           rsp_tuser, want.status.name()));
               if (got.occupancy !== want.occupancy)
                  report_failure($sformatf("occupancy got %0d, expected %0d",
                                           got.occupancy, want.occupancy));
            end
         end
         if (req_tvalid && req_tready) begin
            step_deque(cbdq_pkg::op_type'(req_tuser), req_tdata, want);
            pending_results.push_back(want);
         end
      end
      mismatch_count <= fail_tally;
      outstanding    <= pending_results.size();
   end

endmodule

// File: test/circular_buffer_deque_core_test.sv
`timescale 1ns / 1ps

module circular_buffer_deque_core_test;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = cbdq_pkg::OP_PUSH_FRONT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int          mismatch_count;
   int          outstanding;

   int unsigned requests_sent  = 0;
   int unsigned responses_seen = 0;
   bit          sender_steady   = 1'b0;
   bit          receiver_steady = 1'b0;

   localparam int unsigned REQUEST_TOTAL = 1550;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned DRAIN_LIMIT   = 5000;
   localparam int unsigned BACKLOG_AT    = 300;
   localparam int unsigned BACKLOG_HOLD  = 400;

   always #5 clock = ~clock;

   circular_buffer_deque_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   circular_buffer_deque_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Idle cycles before the next handshake; none while a side is in a steady run.
   function automatic int unsigned pick_gap(input bit steady);
      return steady ? 0 : $urandom_range(0, 19);
   endfunction

   // Offers one request and waits until the core takes it. Valid is only lowered
   // when an idle gap is drawn, so back-to-back requests keep it high.
   task automatic send_request(input cbdq_pkg::op_type op, input logic [31:0] value);
      int unsigned gap;
      if ($urandom_range(0, 49) == 0)
         sender_steady = !sender_steady;
      gap = pick_gap(sender_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      requests_sent++;
   endtask

   // Response side: random stalls, steady runs, and one long hold-off so that
   // the core backs up and refuses further requests for a while.
   initial begin
      int unsigned hold;
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0)
            receiver_steady = !receiver_steady;
         hold = (responses_seen == BACKLOG_AT) ? BACKLOG_HOLD : pick_gap(receiver_steady);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_tvalid);
         responses_seen++;
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned drain_cycles;
      int unsigned run_length;
      int unsigned push_chance;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: pops on an empty deque, a push into an empty deque,
      // head wrap-around, extreme words, emptying from both ends.
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());
      send_request(cbdq_pkg::OP_POP_BACK,   $urandom());
      send_request(cbdq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF);
      send_request(cbdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      send_request(cbdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
      send_request(cbdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());
      send_request(cbdq_pkg::OP_POP_BACK,   $urandom());
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());
      send_request(cbdq_pkg::OP_POP_BACK,   $urandom());
      send_request(cbdq_pkg::OP_POP_BACK,   $urandom());
      send_request(cbdq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
      send_request(cbdq_pkg::OP_POP_BACK,   $urandom());
      send_request(cbdq_pkg::OP_PUSH_BACK,  32'h5555_5555);
      send_request(cbdq_pkg::OP_PUSH_BACK,  32'h0000_0001);
      send_request(cbdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFE);
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());
      send_request(cbdq_pkg::OP_POP_FRONT,  $urandom());

      // Random part in runs with a bias towards pushing or popping, so the
      // deque keeps swinging between full and empty and both ends wrap.
      while (requests_sent < REQUEST_TOTAL) begin
         run_length = $urandom_range(20, 90);
         case ($urandom_range(0, 3))
            0:       push_chance = 85;
            1:       push_chance = 15;
            2:       push_chance = 50;
            default: push_chance = $urandom_range(0, 100);
         endcase
         repeat (run_length) begin
            if ($urandom_range(0, 99) < push_chance)
               send_request($urandom_range(0, 1) ? cbdq_pkg::OP_PUSH_BACK
                                                 : cbdq_pkg::OP_PUSH_FRONT, $urandom());
            else
               send_request($urandom_range(0, 1) ? cbdq_pkg::OP_POP_BACK
                                                 : cbdq_pkg::OP_POP_FRONT, $urandom());
         end
      end
      req_tvalid <= 1'b0;

      // Let every predicted response arrive, then allow for stragglers. The
      // first wait lets the count of the last request reach the checker output.
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (outstanding != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
